/* rtl/core/ltbsl_pkg.sv */
// ----------------------------------------------------------------------------
// ltbsl_pkg
// Shared types and constants of the link test beacon sweeper and logger:
// opcodes, result kinds, modes, power table and controller/datapath bundles.
// ----------------------------------------------------------------------------
package ltbsl_pkg;

	// field widths fixed by the interface
	localparam int ADDR_W = 16;
	localparam int BYTE_W = 8;
	localparam int LINE_W = 11;
	localparam int LVL_W  = 5;
	localparam int POS_W  = 5;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDRESS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PACKETS_PER_LEVEL = 2'd1;

	// reset values
	localparam logic [BYTE_W-1:0] PPL_RESET   = 8'd20;
	localparam logic [POS_W-1:0]  POS_RESET   = 5'h1f;
	localparam logic [LINE_W-1:0] LINE_FIRST  = 11'd1;
	localparam logic [BYTE_W-1:0] DELIM_BYTE  = 8'hfe;
	localparam logic [BYTE_W-1:0] ERASE_BYTE  = 8'hff;

	// radio power setting for each level
	localparam logic [BYTE_W-1:0] POWER_TABLE [16] = '{
		8'd79, 8'd77, 8'd75, 8'd74, 8'd73, 8'd72, 8'd71, 8'd70,
		8'd69, 8'd68, 8'd67, 8'd66, 8'd65, 8'd63, 8'd61, 8'd59
	};

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_SEND_DONE = 3'd1,
		OP_RECEIVED  = 3'd2,
		OP_LOG_DONE  = 3'd3,
		OP_START     = 3'd4,
		OP_FLUSH     = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_SEND  = 2'd0,
		KIND_POWER = 2'd1,
		KIND_LOG   = 2'd2
	} kind_t;

	// operating mode, one-hot
	typedef enum logic [2:0] {
		MODE_IDLE   = 3'b001,
		MODE_BEACON = 3'b010,
		MODE_FLUSH  = 3'b100
	} mode_t;

	// what the item in hand produces
	typedef enum logic [1:0] {
		RES_NONE = 2'd0,
		RES_ONE  = 2'd1,
		RES_LINE = 2'd2
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic       capture;
		logic       commit;
		logic       load_single;
		logic       load_byte;
		logic [3:0] byte_idx;
		logic       byte_last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		res_t res;
	} status_t;

endpackage

/* rtl/core/link_test_beacon_sweeper_logger_top.sv */
// ----------------------------------------------------------------------------
// link_test_beacon_sweeper_logger_top
// Event controller of a radio link test node: beacon power sweep and logging
// of received beacons into 16-byte log lines.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event word: tick, send done,
//   beacon received, log write done, start or flush, with its fields.
//   Output channel (out_valid/out_ready) carries result words: a send beacon
//   request, a power setting, or one byte of a log line; last marks the final
//   word caused by an event.
//   Config channel (cfg_valid/cfg_ready, always ready) writes local_address
//   (index 0) or packets_per_level (index 1); other indexes are ignored.
//   Write configuration only while no event is in progress.
// Timing:
//   An event is captured when taken and committed once the output register
//   is free; a single result is loaded into the output register at the
//   commit, and the next event is taken only after that.
//   A log line streams sixteen bytes, one per cycle unless the receiver
//   stalls, from the log ring flops; no new event is taken until the last
//   byte of the line is loaded.
//   A stalled receiver holds the output register and the sequencer waits.
// Reset:
//   Idle mode, counters cleared, line counter 1, packets_per_level 20; log
//   ring contents are undefined until written.
// ----------------------------------------------------------------------------
module link_test_beacon_sweeper_logger_top #(
	parameter int LINE_LIMIT  = 2047,
	parameter int LEVEL_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic        send_accepted,
	input  logic        own_message,
	input  logic [15:0] msg_src,
	input  logic [7:0]  msg_seq,
	input  logic [7:0]  msg_power,
	input  logic        write_success,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] beacon_src,
	output logic [7:0]  beacon_seq,
	output logic [7:0]  power_level,
	output logic [10:0] line_number,
	output logic [7:0]  line_byte,
	output logic        last
);

	ltbsl_pkg::cmd_t    cmd;
	ltbsl_pkg::status_t status;

	// registers accept a write every cycle
	assign cfg_ready = 1'b1;

	ltbsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	ltbsl_dp #(
		.LINE_LIMIT  (LINE_LIMIT),
		.LEVEL_COUNT (LEVEL_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.opcode        (opcode),
		.send_accepted (send_accepted),
		.own_message   (own_message),
		.msg_src       (msg_src),
		.msg_seq       (msg_seq),
		.msg_power     (msg_power),
		.write_success (write_success),
		.cmd           (cmd),
		.status        (status),
		.kind          (kind),
		.beacon_src    (beacon_src),
		.beacon_seq    (beacon_seq),
		.power_level   (power_level),
		.line_number   (line_number),
		.line_byte     (line_byte),
		.last          (last)
	);

endmodule

/* rtl/core/ltbsl_ctrl.sv */
// ----------------------------------------------------------------------------
// ltbsl_ctrl
// Sequencer: takes one word at a time, has the datapath commit it and, for a
// log line, streams it byte by byte into the output register.
// ----------------------------------------------------------------------------
module ltbsl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  ltbsl_pkg::status_t  status,
	output ltbsl_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EVAL = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] byte_idx_q;
	logic       out_valid_q;
	logic       slot_free;

	// output register can take a word this cycle
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					case (status.res)
						ltbsl_pkg::RES_ONE: begin
							cmd.load_single = 1'b1;
							state_d         = S_IDLE;
						end
						ltbsl_pkg::RES_LINE: state_d = S_EMIT;
						default:             state_d = S_IDLE;
					endcase
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.load_byte = 1'b1;
					cmd.byte_idx  = byte_idx_q;
					cmd.byte_last = (byte_idx_q == 4'hf);
					if (byte_idx_q == 4'hf) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state, byte counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			byte_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				byte_idx_q <= '0;
			end else if (cmd.load_byte) begin
				byte_idx_q <= byte_idx_q + 4'd1;
			end
			if (cmd.load_single || cmd.load_byte) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a waiting word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(cmd.load_single || cmd.load_byte))
		else $error("output word overwritten while stalled");

	// a line always starts at its first byte
	a_line_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && cmd.commit && status.res == ltbsl_pkg::RES_LINE)
		|=> (state_q == S_EMIT && byte_idx_q == 4'd0))
		else $error("log line did not start at byte zero");

	// streaming ends only after the closing byte went out
	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q == S_EMIT) |-> $past(cmd.load_byte && cmd.byte_last))
		else $error("log line cut short");

endmodule

/* rtl/core/ltbsl_dp.sv */
// ----------------------------------------------------------------------------
// ltbsl_dp
// Datapath: configuration, beaconing and logging state, the 32-byte log ring
// and the output register.
// ----------------------------------------------------------------------------
module ltbsl_dp #(
	parameter int LINE_LIMIT  = 2047,
	parameter int LEVEL_COUNT = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic [2:0]           opcode,
	input  logic                 send_accepted,
	input  logic                 own_message,
	input  logic [15:0]          msg_src,
	input  logic [7:0]           msg_seq,
	input  logic [7:0]           msg_power,
	input  logic                 write_success,
	input  ltbsl_pkg::cmd_t      cmd,
	output ltbsl_pkg::status_t   status,
	output logic [1:0]           kind,
	output logic [15:0]          beacon_src,
	output logic [7:0]           beacon_seq,
	output logic [7:0]           power_level,
	output logic [10:0]          line_number,
	output logic [7:0]           line_byte,
	output logic                 last
);

	localparam logic [15:0] LIMIT_V = 16'(LINE_LIMIT);
	localparam logic [4:0]  LEVEL_V = 5'(LEVEL_COUNT);

	// captured word
	logic [2:0]  op_q;
	logic        accepted_q;
	logic        own_q;
	logic [15:0] src_q;
	logic [7:0]  seq_q;
	logic [7:0]  pwr_q;
	logic        ok_q;

	// configuration
	logic [15:0] local_addr_q;
	logic [7:0]  ppl_q;

	// control state
	ltbsl_pkg::mode_t mode_q, mode_d;
	logic        send_busy_q, send_busy_d;
	logic [7:0]  next_seq_q, next_seq_d;
	logic [4:0]  level_q, level_d;
	logic [7:0]  sent_q, sent_d;
	logic [4:0]  wp_q, wp_d;
	logic        half_q, half_d;
	logic [10:0] line_q, line_d;
	logic        log_busy_q, log_busy_d;
	logic [15:0] last_src_q, last_src_d;

	// log ring and line being streamed
	logic [7:0]  ring_q [32];
	logic [10:0] emit_line_q, emit_line_d;
	logic        emit_base_q, emit_base_d;

	// single result and ring writes of the item
	ltbsl_pkg::res_t res;
	logic [1:0]  one_kind;
	logic [15:0] one_src;
	logic [7:0]  one_seq;
	logic [7:0]  one_pwr;
	logic [2:0]  push_n;
	logic [7:0]  push_byte [6];
	logic        erase_ring;

	logic [7:0]  sent_inc;
	logic [4:0]  level_inc;
	logic [10:0] line_inc;

	// output register
	logic [1:0]  kind_q;
	logic [15:0] beacon_src_q;
	logic [7:0]  beacon_seq_q;
	logic [7:0]  power_level_q;
	logic [10:0] line_number_q;
	logic [7:0]  line_byte_q;
	logic        last_q;

	assign sent_inc  = sent_q + 8'd1;
	assign level_inc = level_q + 5'd1;
	assign line_inc  = line_q + 11'd1;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= opcode;
			accepted_q <= send_accepted;
			own_q      <= own_message;
			src_q      <= msg_src;
			seq_q      <= msg_seq;
			pwr_q      <= msg_power;
			ok_q       <= write_success;
		end
	end

	// effect of the captured word
	always_comb begin
		mode_d      = mode_q;
		send_busy_d = send_busy_q;
		next_seq_d  = next_seq_q;
		level_d     = level_q;
		sent_d      = sent_q;
		wp_d        = wp_q;
		half_d      = half_q;
		line_d      = line_q;
		log_busy_d  = log_busy_q;
		last_src_d  = last_src_q;
		emit_line_d = line_q;
		emit_base_d = 1'b0;
		res         = ltbsl_pkg::RES_NONE;
		one_kind    = ltbsl_pkg::KIND_SEND;
		one_src     = '0;
		one_seq     = '0;
		one_pwr     = '0;
		push_n      = 3'd0;
		erase_ring  = 1'b0;
		for (int k = 0; k < 6; k++) begin
			push_byte[k] = '0;
		end
		case (op_q)
			ltbsl_pkg::OP_TICK: begin
				if (mode_q == ltbsl_pkg::MODE_BEACON && !send_busy_q) begin
					res     = ltbsl_pkg::RES_ONE;
					one_src = local_addr_q;
					one_seq = next_seq_q;
					one_pwr = ltbsl_pkg::POWER_TABLE[level_q[3:0]];
					if (accepted_q) begin
						send_busy_d = 1'b1;
						next_seq_d  = next_seq_q + 8'd1;
					end
				end
			end
			ltbsl_pkg::OP_SEND_DONE: begin
				if (own_q) begin
					send_busy_d = 1'b0;
					sent_d      = sent_inc;
					if (sent_inc == ppl_q && level_q < LEVEL_V) begin
						level_d = level_inc;
						if (level_inc >= LEVEL_V) begin
							mode_d = ltbsl_pkg::MODE_IDLE;
						end else begin
							sent_d   = '0;
							res      = ltbsl_pkg::RES_ONE;
							one_kind = ltbsl_pkg::KIND_POWER;
							one_pwr  = ltbsl_pkg::POWER_TABLE[level_inc[3:0]];
						end
					end
				end
			end
			ltbsl_pkg::OP_RECEIVED: begin
				if (last_src_q != src_q) begin
					last_src_d   = src_q;
					push_n       = 3'd6;
					push_byte[0] = ltbsl_pkg::DELIM_BYTE;
					push_byte[1] = ltbsl_pkg::DELIM_BYTE;
					push_byte[2] = src_q[15:8];
					push_byte[3] = src_q[7:0];
					push_byte[4] = seq_q;
					push_byte[5] = pwr_q;
					wp_d         = wp_q + 5'd6;
				end else begin
					push_n       = 3'd2;
					push_byte[0] = seq_q;
					push_byte[1] = pwr_q;
					wp_d         = wp_q + 5'd2;
				end
				// a half of the ring just filled
				if (wp_d[4] != half_q && !log_busy_q && 16'(line_q) < LIMIT_V) begin
					res         = ltbsl_pkg::RES_LINE;
					emit_line_d = line_q;
					emit_base_d = half_q;
					line_d      = line_inc;
					log_busy_d  = 1'b1;
				end
			end
			ltbsl_pkg::OP_LOG_DONE: begin
				if (ok_q) begin
					log_busy_d = 1'b0;
					if (mode_q == ltbsl_pkg::MODE_FLUSH) begin
						if (16'(line_inc) == LIMIT_V) begin
							line_d = ltbsl_pkg::LINE_FIRST;
							mode_d = ltbsl_pkg::MODE_IDLE;
						end else begin
							line_d      = line_inc;
							res         = ltbsl_pkg::RES_LINE;
							emit_line_d = line_inc;
							log_busy_d  = 1'b1;
						end
					end else begin
						half_d = wp_q[4];
					end
				end
			end
			ltbsl_pkg::OP_START: begin
				if (src_q == local_addr_q) begin
					mode_d     = ltbsl_pkg::MODE_BEACON;
					sent_d     = '0;
					level_d    = '0;
					next_seq_d = '0;
					res        = ltbsl_pkg::RES_ONE;
					one_kind   = ltbsl_pkg::KIND_POWER;
					one_pwr    = ltbsl_pkg::POWER_TABLE[0];
				end
			end
			ltbsl_pkg::OP_FLUSH: begin
				mode_d     = ltbsl_pkg::MODE_FLUSH;
				line_d     = ltbsl_pkg::LINE_FIRST;
				erase_ring = 1'b1;
				if (!log_busy_q) begin
					res         = ltbsl_pkg::RES_LINE;
					emit_line_d = ltbsl_pkg::LINE_FIRST;
					log_busy_d  = 1'b1;
				end
			end
			default: res = ltbsl_pkg::RES_NONE;
		endcase
	end

	assign status.res = res;

	// configuration registers and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q <= '0;
			ppl_q        <= ltbsl_pkg::PPL_RESET;
			mode_q       <= ltbsl_pkg::MODE_IDLE;
			send_busy_q  <= 1'b0;
			next_seq_q   <= '0;
			level_q      <= '0;
			sent_q       <= '0;
			wp_q         <= ltbsl_pkg::POS_RESET;
			half_q       <= 1'b0;
			line_q       <= ltbsl_pkg::LINE_FIRST;
			log_busy_q   <= 1'b0;
			last_src_q   <= '0;
		end else begin
			if (cfg_valid && cfg_index == ltbsl_pkg::CFG_LOCAL_ADDRESS) begin
				local_addr_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == ltbsl_pkg::CFG_PACKETS_PER_LEVEL) begin
				ppl_q <= cfg_data[7:0];
			end
			if (cmd.commit) begin
				mode_q      <= mode_d;
				send_busy_q <= send_busy_d;
				next_seq_q  <= next_seq_d;
				level_q     <= level_d;
				sent_q      <= sent_d;
				wp_q        <= wp_d;
				half_q      <= half_d;
				line_q      <= line_d;
				log_busy_q  <= log_busy_d;
				last_src_q  <= last_src_d;
			end
		end
	end

	// log ring writes and line setup
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			emit_line_q <= emit_line_d;
			emit_base_q <= emit_base_d;
			if (erase_ring) begin
				for (int e = 0; e < 16; e++) begin
					ring_q[e] <= ltbsl_pkg::ERASE_BYTE;
				end
			end
			for (int k = 0; k < 6; k++) begin
				if (3'(k) < push_n) begin
					ring_q[wp_q + 5'(k + 1)] <= push_byte[k];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_single) begin
			kind_q        <= one_kind;
			beacon_src_q  <= one_src;
			beacon_seq_q  <= one_seq;
			power_level_q <= one_pwr;
			line_number_q <= '0;
			line_byte_q   <= '0;
			last_q        <= 1'b1;
		end else if (cmd.load_byte) begin
			kind_q        <= ltbsl_pkg::KIND_LOG;
			beacon_src_q  <= '0;
			beacon_seq_q  <= '0;
			power_level_q <= '0;
			line_number_q <= emit_line_q;
			line_byte_q   <= ring_q[{emit_base_q, cmd.byte_idx}];
			last_q        <= cmd.byte_last;
		end
	end

	assign kind        = kind_q;
	assign beacon_src  = beacon_src_q;
	assign beacon_seq  = beacon_seq_q;
	assign power_level = power_level_q;
	assign line_number = line_number_q;
	assign line_byte   = line_byte_q;
	assign last        = last_q;

endmodule
